// ===== design/accelerating_key_repeat_stepper_macros.svh =====
// Assertion macros for the key repeat stepper.
`ifndef ACCELERATING_KEY_REPEAT_STEPPER_MACROS_SVH
`define ACCELERATING_KEY_REPEAT_STEPPER_MACROS_SVH

`ifndef SYNTH
// Checked property, disabled during reset.
`define AKRS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("akrs assertion failed");
// Checked property, also during reset.
`define AKRS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("akrs assertion failed");
`else
`define AKRS_ASSERT(label, prop)
`define AKRS_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== design/akrs_pkg.sv =====
`default_nettype none
package akrs_pkg;

    localparam logic [15:0] HOLD_START_MS = 16'd500;
    localparam logic [15:0] MIN_REPEAT_MS = 16'd50;
    localparam logic [15:0] ACCEL_DIVISOR = 16'd30;

    localparam int unsigned IDX_W = 16;
    localparam int unsigned CFG_W = 16;

    typedef enum logic [1:0] {
        BTN_NONE = 2'd0,
        BTN_DOWN = 2'd1,
        BTN_UP   = 2'd2
    } t_button;

    typedef enum logic [0:0] {
        CFG_ITEM_COUNT = 1'b0,
        CFG_BASE_DELAY = 1'b1
    } t_cfg_index;

endpackage
`default_nettype wire

// ===== design/akrs_repeat_timer.sv =====
`default_nettype none
module akrs_repeat_timer #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic [TIME_WIDTH-1:0]    i_now,
    input  wire logic [TIME_WIDTH-1:0]    i_press_start,
    input  wire logic [TIME_WIDTH-1:0]    i_last_step,
    input  wire logic [akrs_pkg::CFG_W-1:0] i_base_delay,
    output logic                          o_due
);
    import akrs_pkg::*;

    // hold time past the start threshold is compared against k*30
    // instead of dividing it by 30
    localparam int EXT_W  = TIME_WIDTH + 5;
    localparam int PROD_W = CFG_W + 5;

    logic [TIME_WIDTH-1:0] held;
    logic [TIME_WIDTH-1:0] since_step;
    logic [TIME_WIDTH-1:0] past_hold;
    logic [EXT_W-1:0]      past_hold_ext;
    logic                  hold_ok;
    logic [CFG_W-1:0]      base_off;
    logic [PROD_W-1:0]     floor_lim;
    logic                  at_floor;
    logic [CFG_W-1:0]      remain;
    logic [PROD_W-1:0]     remain_lim;
    logic                  due_floor;
    logic                  due_accel;

    always_comb begin
        held          = i_now - i_press_start;
        since_step    = i_now - i_last_step;
        hold_ok       = held >= TIME_WIDTH'(HOLD_START_MS);
        past_hold     = held - TIME_WIDTH'(HOLD_START_MS);
        past_hold_ext = {5'b0, past_hold};

        base_off  = i_base_delay - MIN_REPEAT_MS;
        floor_lim = PROD_W'(base_off) * PROD_W'(ACCEL_DIVISOR);
        at_floor  = (i_base_delay <= MIN_REPEAT_MS) || (past_hold_ext >= EXT_W'(floor_lim));
        due_floor = since_step >= TIME_WIDTH'(MIN_REPEAT_MS);

        // only meaningful when since_step < base, which then fits in CFG_W bits
        remain     = i_base_delay - since_step[CFG_W-1:0];
        remain_lim = PROD_W'(remain) * PROD_W'(ACCEL_DIVISOR);
        due_accel  = (since_step >= TIME_WIDTH'(i_base_delay))
                     || (past_hold_ext >= EXT_W'(remain_lim));

        o_due = hold_ok && (at_floor ? due_floor : due_accel);
    end

endmodule
`default_nettype wire

// ===== design/accelerating_key_repeat_stepper.sv =====
// Structure: input register, one pass of logic, output register.
// Throughput: one word per cycle while i_out_ready is high or the output is empty.
// Button state, press and step times and the next word's view of them are updated
// in the same pass, so back-to-back words see each other's effect.
// Reset (synchronous, active low): no button held, times zero, item count 0,
// base repeat delay 200 ms, both pipeline registers empty.
`default_nettype none
`include "accelerating_key_repeat_stepper_macros.svh"
module accelerating_key_repeat_stepper #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,

    input  wire logic                         i_cfg_we,
    input  wire logic [0:0]                   i_cfg_index,
    input  wire logic [akrs_pkg::CFG_W-1:0]   i_cfg_data,

    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [31:0]                  i_now_ms,
    input  wire logic                         i_down_pressed,
    input  wire logic                         i_up_pressed,
    input  wire logic [akrs_pkg::IDX_W-1:0]   i_cur_index,

    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [akrs_pkg::IDX_W-1:0]        o_new_index,
    output logic                              o_clear_request
);
    import akrs_pkg::*;

    logic [CFG_W-1:0]      r_item_count;
    logic [CFG_W-1:0]      r_base_delay;

    logic                  r_in_valid;
    logic [TIME_WIDTH-1:0] r_in_now;
    logic                  r_in_down;
    logic                  r_in_up;
    logic [IDX_W-1:0]      r_in_index;

    t_button               r_held;
    logic [TIME_WIDTH-1:0] r_press_start;
    logic [TIME_WIDTH-1:0] r_last_step;

    logic                  r_out_valid;
    logic [IDX_W-1:0]      r_out_index;
    logic                  r_out_clear;

    t_button               n_held;
    logic [TIME_WIDTH-1:0] n_press_start;
    logic [TIME_WIDTH-1:0] n_last_step;
    logic [IDX_W-1:0]      n_index;
    logic                  n_clear;

    logic [TIME_WIDTH+31:0] now_wide;
    logic                   advance;
    logic                   count_zero;
    t_button                btn;
    logic                   fresh;
    logic                   step;
    logic                   repeat_due;

    assign now_wide   = {{TIME_WIDTH{1'b0}}, i_now_ms};
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= '0;
            r_base_delay <= CFG_W'(200);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ITEM_COUNT: r_item_count <= i_cfg_data;
                CFG_BASE_DELAY: r_base_delay <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_now   <= now_wide[TIME_WIDTH-1:0];
            r_in_down  <= i_down_pressed;
            r_in_up    <= i_up_pressed;
            r_in_index <= i_cur_index;
        end
    end

    akrs_repeat_timer #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_timer (
        .i_now         (r_in_now),
        .i_press_start (r_press_start),
        .i_last_step   (r_last_step),
        .i_base_delay  (r_base_delay),
        .o_due         (repeat_due)
    );

    always_comb begin
        count_zero = r_item_count == '0;
        if (r_in_down) begin
            btn = BTN_DOWN;
        end else if (r_in_up) begin
            btn = BTN_UP;
        end else begin
            btn = BTN_NONE;
        end
        fresh = (btn != BTN_NONE) && (r_held == BTN_NONE);
        if (fresh) begin
            step = 1'b1;
        end else if (btn == BTN_NONE || btn != r_held) begin
            step = 1'b0;
        end else begin
            step = repeat_due;
        end

        n_index = r_in_index;
        n_clear = 1'b0;
        if (step) begin
            if (btn == BTN_DOWN && r_in_index < r_item_count - 16'd1) begin
                n_index = r_in_index + 16'd1;
                n_clear = 1'b1;
            end else if (btn == BTN_UP && r_in_index != '0) begin
                n_index = r_in_index - 16'd1;
                n_clear = 1'b1;
            end
        end
        if (count_zero) begin
            n_index = '0;
            n_clear = 1'b0;
        end

        n_held        = r_held;
        n_press_start = r_press_start;
        n_last_step   = r_last_step;
        if (!count_zero) begin
            n_held = btn;
            if (fresh) begin
                n_press_start = r_in_now;
            end
            if (step) begin
                n_last_step = r_in_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held        <= BTN_NONE;
            r_press_start <= '0;
            r_last_step   <= '0;
            r_out_valid   <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_held        <= n_held;
                r_press_start <= n_press_start;
                r_last_step   <= n_last_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_index <= n_index;
            r_out_clear <= n_clear;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_new_index     = r_out_index;
    assign o_clear_request = r_out_clear;

    `AKRS_ASSERT(a_zero_count_out, (r_in_valid && advance && count_zero)
        |=> (r_out_valid && r_out_index == '0 && !r_out_clear))
    `AKRS_ASSERT(a_zero_count_hold, (r_in_valid && advance && count_zero)
        |=> ($stable(r_held) && $stable(r_press_start) && $stable(r_last_step)))
    `AKRS_ASSERT(a_step_needs_button, (r_in_valid && advance && n_clear)
        |=> (r_held != BTN_NONE))
    `AKRS_ASSERT(a_release_clears,
        (r_in_valid && advance && !count_zero && !r_in_down && !r_in_up)
        |=> (r_held == BTN_NONE))

endmodule
`default_nettype wire
